>>> design/stdf_pkg.sv
// ----------------------------------------------------------------------------
// Sieve factorizer package
// Shared constants, types and state encodings for the sieve factorizer.
// ----------------------------------------------------------------------------
`default_nettype none
package stdf_pkg;

  localparam int unsigned SieveSizeDef = 65536;
  localparam int unsigned MaxPrimesDef = 8192;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned ExpW         = 6;
  localparam int unsigned CountW       = 14;
  localparam int unsigned LimitW       = 16;
  localparam logic [LimitW-1:0] LimitRst = 16'hFFFF;

  localparam logic ReqBuild     = 1'b0;
  localparam logic ReqFactorize = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StScan,
    StScanWait,
    StMark,
    StFetch,
    StFetchWait,
    StCheck,
    StDivStart,
    StDivWait,
    StEmit,
    StLeftover,
    StDone
  } state_e;

  // Divider request/response bundle.
  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] dividend;
    logic [ValueW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] quotient;
    logic              rem_zero;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> design/stdf_divider.sv
// ----------------------------------------------------------------------------
// Sieve factorizer divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module stdf_divider
  import stdf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(ValueW + 1);

  logic [ValueW-1:0] quo_q, quo_d;
  logic [ValueW:0]   rem_q, rem_d;
  logic [ValueW-1:0] dsr_q, dsr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [ValueW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[ValueW-1:0], quo_q[ValueW-1]} - {1'b0, dsr_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = CntW'(ValueW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[ValueW]) begin
        rem_d = trial;
        quo_d = {quo_q[ValueW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[ValueW-1:0], quo_q[ValueW-1]};
        quo_d = {quo_q[ValueW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
  assign rsp_o.rem_zero = (rem_q == '0);

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("divider count slip");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider not busy after start");

endmodule
`default_nettype wire

>>> design/sieve_trial_division_factorizer.sv
// ----------------------------------------------------------------------------
// Sieve trial-division factorizer
// Builds a prime bitmap and list in memory, then factorizes values by them.
// ----------------------------------------------------------------------------
//  Channel   Signals                                         Direction
//  request   req_valid_i, req_stall_o, req_type_i, value_i    in
//  result    res_valid_o, res_stall_i, prime_o, exponent_o,   out
//            prime_count_o, last_o
//  config    cfg_we_i, cfg_wdata_i                            in
//
// A build first clears the bitmap up to the limit, then scans each entry and,
// for each prime found, marks its multiples from its square as composite; all
// of this shares the single bitmap memory port. A factorize fetches and checks
// each listed prime tried, runs a trial division for it (start, quotient bits,
// completion) and records the factor.
// Reset leaves the memories unwritten and the prime list empty; a build clears
// the bitmap up to the limit first.
// Requests are taken only while idle. A stalled result beat holds the block
// once it reaches an emit, leftover or done step.
`default_nettype none
module sieve_trial_division_factorizer
  import stdf_pkg::*;
#(
  parameter int unsigned SIEVE_SIZE = SieveSizeDef,
  parameter int unsigned MAX_PRIMES = MaxPrimesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LimitW-1:0] cfg_wdata_i,
  input  wire logic              req_valid_i,
  output logic                   req_stall_o,
  input  wire logic              req_type_i,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   res_valid_o,
  input  wire logic              res_stall_i,
  output logic [ValueW-1:0]      prime_o,
  output logic [ExpW-1:0]        exponent_o,
  output logic [CountW-1:0]      prime_count_o,
  output logic                   last_o
);

  localparam int unsigned AW  = $clog2(SIEVE_SIZE);
  localparam int unsigned PW  = $clog2(MAX_PRIMES);
  localparam int unsigned PCW = PW + 1;
  localparam int unsigned SW  = AW + 1;
  localparam int unsigned JW  = 2 * AW;
  localparam int unsigned LCW = (SW > LimitW) ? SW : LimitW;
  localparam int unsigned NCW = (JW > ValueW) ? JW : ValueW;
  localparam logic [SW-1:0] SieveMax = SW'(SIEVE_SIZE - 1);

  // Bitmap stores 1 = composite after clearing.
  logic flags_mem [SIEVE_SIZE];
  logic [AW-1:0] list_mem [MAX_PRIMES];

  state_e state_q, state_d;
  logic [LimitW-1:0] limit_q;
  logic [SW-1:0]     lim_q, lim_d;
  logic [SW-1:0]     i_q, i_d;
  logic [JW-1:0]     j_q, j_d;
  logic [PCW-1:0]    cnt_q, cnt_d;
  logic [PCW-1:0]    idx_q, idx_d;
  logic [ValueW-1:0] n_q, n_d;
  logic [AW-1:0]     p_q, p_d;
  logic [ExpW-1:0]   e_q, e_d;
  logic              build_q, build_d;
  logic              ov_q;

  logic          fl_we, fl_wd, fl_rd_q;
  logic [AW-1:0] fl_addr;
  logic          ls_we;
  logic [PW-1:0] ls_addr;
  logic [AW-1:0] ls_rd_q;

  logic              ov_take, in_take, room;
  div_req_t          dreq;
  div_rsp_t          drsp;
  logic [JW-1:0]     isq, psq;

  // Staging register: a factor result sits here until the next one or the end.
  logic              stg_q, stg_d;
  logic [ValueW-1:0] sp_q, sp_d;
  logic [ExpW-1:0]   se_q, se_d;
  logic              stage_fire;
  logic [ValueW-1:0] fire_p;
  logic [ExpW-1:0]   fire_e;
  logic [CountW-1:0] fire_c;
  logic              fire_l;

  always_ff @(posedge clk_i) begin
    if (fl_we) flags_mem[fl_addr] <= fl_wd;
    fl_rd_q <= flags_mem[fl_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ls_we) list_mem[ls_addr] <= i_q[AW-1:0];
    ls_rd_q <= list_mem[ls_addr];
  end

  stdf_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign ov_take     = ov_q && !res_stall_i;
  assign room        = !ov_q || ov_take;
  assign req_stall_o = (state_q != StIdle);
  assign in_take     = req_valid_i && !req_stall_o;
  assign isq         = {{AW{1'b0}}, i_q[AW-1:0]} * {{AW{1'b0}}, i_q[AW-1:0]};
  assign psq         = {{AW{1'b0}}, p_q} * {{AW{1'b0}}, p_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_take) state_d = (req_type_i == ReqBuild) ? StClear : StFetch;
      StClear: if (i_q == lim_q) state_d = StScan;
      StScan: state_d = (i_q > lim_q) ? StDone : StScanWait;
      StScanWait: state_d = fl_rd_q ? StScan : StMark;
      StMark: if (j_q > JW'(lim_q)) state_d = StScan;
      StFetch: state_d = (idx_q == cnt_q) ? StLeftover : StFetchWait;
      StFetchWait: state_d = StCheck;
      StCheck: state_d = (p_q < AW'(2) || NCW'(psq) > NCW'(n_q))
                         ? StLeftover : StDivStart;
      StDivStart: state_d = StDivWait;
      StDivWait: if (drsp.done) state_d = drsp.rem_zero ? StDivStart : StEmit;
      StEmit: if (room) state_d = StFetch;
      StLeftover: if (room) state_d = StDone;
      StDone: if (room) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    lim_d = lim_q; i_d = i_q; j_d = j_q; cnt_d = cnt_q; idx_d = idx_q;
    n_d = n_q; p_d = p_q; e_d = e_q; build_d = build_q;
    fl_we = 1'b0; fl_wd = 1'b0; fl_addr = i_q[AW-1:0];
    ls_we = 1'b0; ls_addr = idx_q[PW-1:0];
    dreq.start = 1'b0; dreq.dividend = n_q; dreq.divisor = ValueW'(p_q);
    unique case (state_q)
      StIdle: begin
        if (in_take) begin
          build_d = (req_type_i == ReqBuild);
          if (req_type_i == ReqBuild) begin
            lim_d = (LCW'(limit_q) > LCW'(SieveMax)) ? SieveMax : SW'(limit_q);
            i_d   = '0;
            cnt_d = '0;
          end else begin
            n_d = value_i; idx_d = '0;
          end
        end
      end
      StClear: begin
        fl_we = 1'b1;
        fl_wd = (i_q < SW'(2));
        i_d   = (i_q == lim_q) ? SW'(2) : i_q + SW'(1);
      end
      StScanWait: begin
        if (fl_rd_q) i_d = i_q + SW'(1);
        else begin
          j_d = isq;
          if (cnt_q < PCW'(MAX_PRIMES)) begin
            ls_we = 1'b1; ls_addr = cnt_q[PW-1:0]; cnt_d = cnt_q + PCW'(1);
          end
        end
      end
      StMark: begin
        fl_addr = j_q[AW-1:0];
        if (j_q <= JW'(lim_q)) begin
          fl_we = 1'b1; fl_wd = 1'b1;
          j_d = j_q + JW'(i_q);
        end else i_d = i_q + SW'(1);
      end
      StFetch: e_d = '0;
      StFetchWait: p_d = ls_rd_q;
      StDivStart: dreq.start = 1'b1;
      StDivWait: begin
        if (drsp.done && drsp.rem_zero) begin
          n_d = drsp.quotient; e_d = e_q + ExpW'(1);
        end
      end
      StEmit: if (room) idx_d = idx_q + PCW'(1);
      default: ;
    endcase
  end

  always_comb begin
    stg_d = stg_q; sp_d = sp_q; se_d = se_q;
    stage_fire = 1'b0;
    fire_p = sp_q; fire_e = se_q; fire_c = '0; fire_l = 1'b0;
    if (state_q == StIdle && in_take) stg_d = 1'b0;
    if (state_q == StEmit && room && e_q != '0) begin
      if (stg_q) stage_fire = 1'b1;
      stg_d = 1'b1; sp_d = ValueW'(p_q); se_d = e_q;
    end
    if (state_q == StLeftover && room && n_q > ValueW'(1)) begin
      if (stg_q) stage_fire = 1'b1;
      stg_d = 1'b1; sp_d = n_q; se_d = ExpW'(1);
    end
    if (state_q == StDone && room) begin
      if (build_q) begin
        stage_fire = 1'b1; fire_p = '0; fire_e = '0;
        fire_c = CountW'(cnt_q); fire_l = 1'b1;
      end else if (stg_q) begin
        stage_fire = 1'b1; fire_l = 1'b1; stg_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      limit_q <= LimitRst;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      stg_q   <= 1'b0;
      build_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      cnt_q   <= cnt_d;
      stg_q   <= stg_d;
      build_q <= build_d;
      if (stage_fire)   ov_q <= 1'b1;
      else if (ov_take) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= lim_d; i_q <= i_d; j_q <= j_d; idx_q <= idx_d;
    n_q <= n_d; p_q <= p_d; e_q <= e_d;
    sp_q <= sp_d; se_q <= se_d;
    if (stage_fire) begin
      prime_o       <= fire_p;
      exponent_o    <= fire_e;
      prime_count_o <= fire_c;
      last_o        <= fire_l;
    end
  end

  assign res_valid_o = ov_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> req_stall_o) else $error("request taken while busy");
  a_fire_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire |-> (!ov_q || !res_stall_i)) else $error("result overwritten");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PCW'(MAX_PRIMES)) else $error("prime count overflow");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_stall_i) |=> (ov_q && $stable(prime_o) && $stable(last_o)))
    else $error("stalled result beat changed");

endmodule
`default_nettype wire

>>> bench/sieve_trial_division_factorizer_tb.sv
// ----------------------------------------------------------------------------
// Sieve trial-division factorizer testbench
// Drives build and factorize requests under random idling on both channels.
// A software copy of the sieve predicts every result beat for checking.
// ----------------------------------------------------------------------------
module sieve_trial_division_factorizer_tb;
  import stdf_pkg::*;

  localparam int unsigned CycleLimit = 8000000;

  typedef struct packed {
    logic              kind;
    logic [ValueW-1:0] value;
  } request_t;

  typedef struct packed {
    logic [ValueW-1:0] prime;
    logic [ExpW-1:0]   exponent;
    logic [CountW-1:0] prime_count;
    logic              last;
  } factor_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [LimitW-1:0] cfg_wdata_i;
  logic              req_valid_i;
  logic              req_stall_o;
  logic              req_type_i;
  logic [ValueW-1:0] value_i;
  logic              res_valid_o;
  logic              res_stall_i;
  logic [ValueW-1:0] prime_o;
  logic [ExpW-1:0]   exponent_o;
  logic [CountW-1:0] prime_count_o;
  logic              last_o;

  sieve_trial_division_factorizer dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .req_valid_i, .req_stall_o,
    .req_type_i, .value_i, .res_valid_o, .res_stall_i, .prime_o, .exponent_o,
    .prime_count_o, .last_o
  );

  // Software copy of the block's state.
  bit                composite_map [SieveSizeDef];
  logic [15:0]       primes_seen   [MaxPrimesDef];
  int unsigned       primes_held;
  logic [LimitW-1:0] limit_shadow;

  request_t     pending_reqs [$];
  factor_beat_t expected_beats [$];
  int unsigned  mismatches;
  int unsigned  cycle_count;
  bit           quiet_phase;
  bit           long_hold_req;
  bit           long_hold_done;
  int unsigned  send_gap;
  int unsigned  recv_gap;

  int unsigned primes_small [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 97};

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic sieve_rebuild();
    int unsigned  lim;
    factor_beat_t beat;
    lim = limit_shadow;
    if (lim > SieveSizeDef - 1) lim = SieveSizeDef - 1;
    for (int i = 0; i < SieveSizeDef; i++) composite_map[i] = 1'b0;
    primes_held = 0;
    for (int unsigned i = 2; i <= lim; i++) begin
      if (composite_map[i]) continue;
      for (int unsigned j = i * i; j <= lim; j += i) composite_map[j] = 1'b1;
      if (primes_held < MaxPrimesDef) begin
        primes_seen[primes_held] = i[15:0];
        primes_held++;
      end
    end
    beat = '{prime: '0, exponent: '0, prime_count: primes_held[CountW-1:0], last: 1'b1};
    expected_beats = {expected_beats, beat};
  endtask

  task automatic factor_predict(logic [ValueW-1:0] value);
    longint unsigned rest;
    longint unsigned p;
    int unsigned mult;
    factor_beat_t item;
    factor_beat_t found [$];
    rest = value;
    for (int unsigned idx = 0; idx < primes_held; idx++) begin
      p = primes_seen[idx];
      if (p < 2 || p * p > rest) break;
      mult = 0;
      while (rest % p == 0) begin
        rest = rest / p;
        mult++;
      end
      if (mult > 0 && found.size() < 10) begin
        item  = '{prime: p[31:0], exponent: mult[5:0], prime_count: '0, last: 1'b0};
        found = {found, item};
      end
    end
    if (rest > 1 && found.size() < 10) begin
      item  = '{prime: rest[31:0], exponent: 6'd1, prime_count: '0, last: 1'b0};
      found = {found, item};
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    expected_beats = {expected_beats, found};
  endtask

  // Request driver: a beat is taken when valid is high and stall is low.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_type_i  <= 1'b0;
      value_i     <= '0;
      send_gap    <= 0;
    end else begin
      if (req_valid_i && !req_stall_o) begin
        if (req_type_i == ReqBuild) sieve_rebuild();
        else factor_predict(value_i);
      end
      if (!req_valid_i || !req_stall_o) begin
        if (send_gap > 0) begin
          req_valid_i <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          request_t r;
          r = pending_reqs.pop_front();
          req_valid_i <= 1'b1;
          req_type_i  <= r.kind;
          value_i     <= r.value;
          if (!quiet_phase && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 11);
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and stall generator.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall_i    <= 1'b0;
      recv_gap       <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (res_valid_o && !res_stall_i) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: prime %0d exp %0d count %0d last %0d",
                     prime_o, exponent_o, prime_count_o, last_o);
        end else begin
          factor_beat_t want;
          want = expected_beats.pop_front();
          if (prime_o !== want.prime || exponent_o !== want.exponent ||
              prime_count_o !== want.prime_count || last_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.prime, want.exponent, want.prime_count, want.last,
                       prime_o, exponent_o, prime_count_o, last_o);
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        recv_gap       <= 4000;
        res_stall_i    <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        res_stall_i <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        recv_gap    <= $urandom_range(0, 10);
        res_stall_i <= 1'b1;
      end else begin
        res_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_req(logic kind, logic [ValueW-1:0] v);
    request_t r;
    r.kind       = kind;
    r.value      = v;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic queue_factor(logic [ValueW-1:0] v);
    queue_req(ReqFactorize, v);
  endtask

  // Waits until all results are in, then lets a trailing zero-result item finish.
  task automatic drain();
    while (pending_reqs.size() > 0 || req_valid_i || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [LimitW-1:0] lim);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_shadow = lim;
  endtask

  function automatic logic [ValueW-1:0] random_value();
    logic [63:0] acc;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom();
    if (pick < 6) return $urandom_range(0, 200);
    acc = 1;
    // Smooth numbers built from small primes exercise high exponents.
    repeat ($urandom_range(1, 30)) begin
      logic [63:0] f;
      f = 64'(primes_small[$urandom_range(0, 9)]);
      if (acc * f > 64'hFFFF_FFFF) break;
      acc = acc * f;
    end
    return acc[31:0];
  endfunction

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    mismatches    = 0;
    cycle_count   = 0;
    quiet_phase   = 1'b0;
    long_hold_req = 1'b0;
    primes_held   = 0;
    limit_shadow  = LimitRst;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With no list any value above one comes back whole with exponent one.
    queue_factor(32'd0);
    queue_factor(32'd1);
    queue_factor(32'd2);
    queue_factor(32'hFFFF_FFFF);
    queue_factor(32'd12);
    drain();

    // A limit below two lists nothing.
    set_limit(16'd0);
    queue_req(ReqBuild, 32'hFFFF_FFFF);
    queue_factor(32'd360);
    queue_factor(32'd1);
    drain();

    set_limit(16'd2);
    queue_req(ReqBuild, '0);
    queue_factor(32'h8000_0000);
    queue_factor(32'd6);
    drain();

    // Rebuild at a larger limit, then random beats with a long receiver hold-off.
    set_limit(16'd100);
    queue_req(ReqBuild, $urandom());
    queue_factor(32'd223092870);
    queue_factor(32'd9409);
    queue_factor(32'd10403);
    repeat (60) queue_factor(random_value());
    long_hold_req = 1'b1;
    drain();

    set_limit(16'd300);
    queue_req(ReqBuild, '0);
    repeat (60) queue_factor(random_value());
    drain();

    // Full-size bitmap, quiet channels for the last part.
    set_limit(16'hFFFF);
    quiet_phase = 1'b1;
    queue_req(ReqBuild, '0);
    queue_factor(32'hFFFF_FFFF);
    queue_factor(32'd4294967291);
    queue_factor(32'd65536);
    repeat (8) begin
      logic [ValueW-1:0] v;
      v = random_value();
      // Keep large unfactorable values rare on the full list.
      if (v > 32'd100000) v = {v[31:12], 12'd0};
      queue_factor(v);
    end
    drain();

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
